### rtl/elementwise_field_statistics_macros.svh
// Assertion macros shared by the statistics block.
`ifndef ELEMENTWISE_FIELD_STATISTICS_MACROS_SVH
`define ELEMENTWISE_FIELD_STATISTICS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFS_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/efs_pkg.sv
package efs_pkg;

   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 10;
   localparam int SAMPLE_W = 32;
   localparam int STAT_W   = 48;
   localparam int COUNT_W  = 16;
   localparam int MODE_W   = 3;

   localparam int ENTRIES_DEFAULT = 1024;

   // Commands carried by an input beat.
   localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // Statistic modes.
   localparam logic [MODE_W-1:0] MODE_INSTANT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_AVERAGE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MINIMUM    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MAXIMUM    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ACCUMULATE = 3'd4;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef logic signed [STAT_W-1:0]   stat_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [COUNT_W-1:0]         count_type;

   // Divider handshake status toward the top level.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Sign-extend a sample to the statistic width.
   function automatic stat_type widen(input sample_type x);
      widen = stat_type'(x);
   endfunction

   // Fold a sample into a stored statistic according to the mode.
   function automatic stat_type combine(input logic [MODE_W-1:0] mode,
                                        input stat_type old_value,
                                        input sample_type x);
      logic signed [STAT_W:0] sum;
      stat_type               wide_x;
      wide_x = widen(x);
      sum    = {old_value[STAT_W-1], old_value} + {wide_x[STAT_W-1], wide_x};
      unique case (mode)
         MODE_AVERAGE, MODE_ACCUMULATE: begin
            // Saturate when the carry and the sign bit disagree.
            if (sum[STAT_W] != sum[STAT_W-1]) begin
               combine = sum[STAT_W] ? {1'b1, {(STAT_W-1){1'b0}}}
                                     : {1'b0, {(STAT_W-1){1'b1}}};
            end else begin
               combine = sum[STAT_W-1:0];
            end
         end
         MODE_MINIMUM: begin
            combine = (wide_x < old_value) ? wide_x : old_value;
         end
         MODE_MAXIMUM: begin
            combine = (wide_x > old_value) ? wide_x : old_value;
         end
         default: begin
            combine = wide_x;
         end
      endcase
   endfunction

endpackage

### rtl/efs_req_if.sv
// Request channel: one beat is an update, a read or a restart.
interface efs_req_if;
   logic                             valid;
   logic                             ready;
   logic [efs_pkg::CMD_W-1:0]        cmd;
   logic [efs_pkg::INDEX_W-1:0]      elem_index;
   logic signed [efs_pkg::SAMPLE_W-1:0] sample;
   logic                             last_elem;

   modport source (output valid, cmd, elem_index, sample, last_elem, input ready);
   modport sink   (input valid, cmd, elem_index, sample, last_elem, output ready);
endinterface

### rtl/efs_rsp_if.sv
// Response channel: one beat per read request.
interface efs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [efs_pkg::STAT_W-1:0] stat_value;
   logic [efs_pkg::INDEX_W-1:0]       out_index;
   logic [efs_pkg::COUNT_W-1:0]       fields_seen;
   logic                              empty_res;

   modport source (output valid, stat_value, out_index, fields_seen, empty_res,
                   input ready);
   modport sink   (input valid, stat_value, out_index, fields_seen, empty_res,
                   output ready);
endinterface

### rtl/efs_store.sv
// Statistic memory: one write port and one read port, registered read data.
module efs_store #(
   parameter int ENTRIES = efs_pkg::ENTRIES_DEFAULT,
   parameter int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  efs_pkg::stat_type wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output efs_pkg::stat_type rd_data
);

   efs_pkg::stat_type mem [ENTRIES];
   efs_pkg::stat_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/efs_div.sv
// Signed 48-bit by unsigned 16-bit divider, truncating toward zero.
// Restoring algorithm on magnitudes, one quotient bit per cycle.
module efs_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  efs_pkg::stat_type          dividend,
   input  efs_pkg::count_type         divisor,
   input  logic                       take,
   output efs_pkg::div_status_type    status,
   output efs_pkg::stat_type          quotient
);

   localparam int STEP_W = $clog2(efs_pkg::STAT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(efs_pkg::STAT_W - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [STEP_W-1:0]             step_ff, step_in;
   logic                          neg_ff, neg_in;
   logic [efs_pkg::STAT_W-1:0]    mag_ff, mag_in;
   logic [efs_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [efs_pkg::COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [efs_pkg::COUNT_W:0]     trial;
   logic                          fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   assign trial = {rem_ff, mag_ff[efs_pkg::STAT_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               step_in  = LAST_STEP;
               neg_in   = dividend[efs_pkg::STAT_W-1];
               mag_in   = dividend[efs_pkg::STAT_W-1] ? -dividend : dividend;
               rem_in   = '0;
               dsr_in   = divisor;
            end
         end
         ST_RUN: begin
            mag_in = {mag_ff[efs_pkg::STAT_W-2:0], fits};
            rem_in = fits ? efs_pkg::COUNT_W'(trial - {1'b0, dsr_ff})
                          : trial[efs_pkg::COUNT_W-1:0];
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   // The magnitude register holds the quotient once the last step is done.
   assign quotient    = neg_ff ? -efs_pkg::stat_type'(mag_ff)
                               : efs_pkg::stat_type'(mag_ff);
   assign status.busy = state_ff != ST_IDLE;
   assign status.done = state_ff == ST_DONE;

endmodule

### rtl/elementwise_field_statistics.sv
// Elementwise field statistics. Each element of a field keeps one statistic in a
// single-port-read, single-port-write memory: latest sample, average, minimum,
// maximum or saturating sum, chosen by the mode register. An update beat is read
// from the memory on acceptance and combined and written back in the next cycle;
// a back-to-back update of the same element is forwarded, so updates, restarts
// and plain reads are taken one per cycle while the response side is free. A
// read's response beat passes the stage register and then the response register.
// An in-range average read with a nonzero field count goes to a one-bit-per-cycle
// divider, and no request beat is accepted until its quotient moves to the
// response register. Reading an element never updated since reset returns an
// undefined value; write the mode register only while the block is idle.
`include "elementwise_field_statistics_macros.svh"

module elementwise_field_statistics #(
   parameter int ENTRIES = efs_pkg::ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   efs_req_if.sink                     req,
   efs_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic [efs_pkg::MODE_W-1:0]  csr_wdata
);

   localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANGE_W = 17;

   logic                          accept;
   logic [efs_pkg::MODE_W-1:0]    mode_ff;
   efs_pkg::count_type            count_ff, count_in;
   efs_pkg::count_type            count_inc;
   logic [RANGE_W-1:0]            req_index_ext;
   logic                          req_in_range;

   // Item waiting for its memory data.
   logic                          s1_valid_ff, s1_valid_in;
   logic [efs_pkg::CMD_W-1:0]     s1_cmd_ff;
   logic [efs_pkg::INDEX_W-1:0]   s1_index_ff;
   efs_pkg::sample_type           s1_sample_ff;
   logic                          s1_in_range_ff;
   logic                          s1_empty_ff;
   efs_pkg::count_type            s1_count_ff;
   logic [ADDR_W-1:0]             s1_addr_ff;

   logic                          fwd_hit_ff;
   efs_pkg::stat_type             fwd_data_ff;

   efs_pkg::stat_type             mem_rdata;
   efs_pkg::stat_type             old_value;
   efs_pkg::stat_type             new_value;
   efs_pkg::stat_type             read_value;
   logic                          s1_we;
   logic                          s1_div;
   logic                          s1_direct;
   logic                          s1_go;
   logic                          out_free;
   logic                          div_take;

   efs_pkg::div_status_type       div_status;
   efs_pkg::stat_type             div_quotient;
   logic [efs_pkg::INDEX_W-1:0]   pend_index_ff;
   efs_pkg::count_type            pend_count_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   efs_pkg::stat_type             rsp_value_ff;
   logic [efs_pkg::INDEX_W-1:0]   rsp_index_ff;
   efs_pkg::count_type            rsp_count_ff;
   logic                          rsp_empty_ff;

   logic                          fwd_due;
   logic                          bump_due;

   assign accept        = req.valid && req.ready;
   assign req_index_ext = RANGE_W'(req.elem_index);
   assign req_in_range  = req_index_ext < RANGE_W'(ENTRIES);

   // Mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= efs_pkg::MODE_INSTANT;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // Field count moves when the beat is accepted, so later beats see it at once.
   assign count_inc = count_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         priority if (req.cmd == efs_pkg::CMD_RESTART) begin
            count_in = '0;
         end else if (req.cmd == efs_pkg::CMD_UPDATE && req.last_elem
                      && count_ff != efs_pkg::COUNT_MAX) begin
            count_in = count_inc;
         end else begin
            count_in = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   efs_store #(
      .ENTRIES (ENTRIES),
      .ADDR_W  (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_we),
      .wr_addr (s1_addr_ff),
      .wr_data (new_value),
      .rd_en   (accept),
      .rd_addr (req_index_ext[ADDR_W-1:0]),
      .rd_data (mem_rdata)
   );

   // Read-modify-write of the stored statistic.
   assign old_value = fwd_hit_ff ? fwd_data_ff : mem_rdata;
   assign new_value = s1_empty_ff ? efs_pkg::widen(s1_sample_ff)
                                  : efs_pkg::combine(mode_ff, old_value, s1_sample_ff);
   assign s1_we     = s1_valid_ff && s1_cmd_ff == efs_pkg::CMD_UPDATE && s1_in_range_ff;

   // Read path: out of range, or an average with no complete field, gives zero.
   assign s1_div    = s1_valid_ff && s1_cmd_ff == efs_pkg::CMD_READ && s1_in_range_ff
                      && mode_ff == efs_pkg::MODE_AVERAGE && !s1_empty_ff;
   assign s1_direct = s1_valid_ff && s1_cmd_ff == efs_pkg::CMD_READ && !s1_div;
   assign read_value = (!s1_in_range_ff || mode_ff == efs_pkg::MODE_AVERAGE)
                       ? '0 : old_value;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s1_go    = !s1_direct || out_free;
   assign div_take = div_status.done && out_free;

   // A read that starts the divider blocks the next beat as well.
   assign req.ready = !div_status.busy && (!s1_valid_ff || (s1_go && !s1_div));

   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff      <= req.cmd;
         s1_index_ff    <= req.elem_index;
         s1_sample_ff   <= req.sample;
         s1_in_range_ff <= req_in_range;
         s1_empty_ff    <= count_ff == '0;
         s1_count_ff    <= count_ff;
         s1_addr_ff     <= req_index_ext[ADDR_W-1:0];
      end
   end

   // The memory returns the old value when the write lands in the same cycle
   // as the read, so the fresh value is kept aside.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (accept) begin
         fwd_hit_ff <= s1_we && s1_index_ff == req.elem_index;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= new_value;
      end
   end

   efs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (s1_div),
      .dividend (old_value),
      .divisor  (s1_count_ff),
      .take     (div_take),
      .status   (div_status),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      if (s1_div) begin
         pend_index_ff <= s1_index_ff;
         pend_count_ff <= s1_count_ff;
      end
   end

   // Response register.
   assign rsp_valid_in = (s1_direct && out_free) || div_take
                         || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      priority if (div_take) begin
         rsp_value_ff <= div_quotient;
         rsp_index_ff <= pend_index_ff;
         rsp_count_ff <= pend_count_ff;
         rsp_empty_ff <= 1'b0;
      end else if (s1_direct && out_free) begin
         rsp_value_ff <= read_value;
         rsp_index_ff <= s1_index_ff;
         rsp_count_ff <= s1_count_ff;
         rsp_empty_ff <= s1_empty_ff;
      end else begin
         rsp_value_ff <= rsp_value_ff;
         rsp_index_ff <= rsp_index_ff;
         rsp_count_ff <= rsp_count_ff;
         rsp_empty_ff <= rsp_empty_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.stat_value  = rsp_value_ff;
   assign rsp.out_index   = rsp_index_ff;
   assign rsp.fields_seen = rsp_count_ff;
   assign rsp.empty_res   = rsp_empty_ff;

   // Conditions watched by the checks below.
   assign fwd_due  = accept && s1_we && s1_index_ff == req.elem_index;
   assign bump_due = accept && req.cmd == efs_pkg::CMD_UPDATE && req.last_elem
                     && count_ff != efs_pkg::COUNT_MAX;

   // Checks.
   `EFS_ASSERT_HOLDS(a_div_stall, clock, reset, div_status.busy, !req.ready, "input not stalled")
   `EFS_ASSERT_HOLDS(a_div_alone, clock, reset, div_status.done, !s1_valid_ff, "item in flight")
   `EFS_ASSERT_NEXT(a_forward_taken, clock, reset, fwd_due, fwd_hit_ff, "update not forwarded")
   `EFS_ASSERT_NEXT(a_bump, clock, reset, bump_due, count_ff == $past(count_inc), "count stuck")

endmodule
